// ----- sv/edu_pkg.sv -----
`timescale 1ns / 1ps
// Package for the Euclidean distance unit: payload structs, the queue entry
// type, back-end state encoding and shared constants. No dependencies.
package edu_pkg;

    localparam int ELEM_W      = 16;
    localparam int MAG_W       = ELEM_W;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SUM_W       = 48;
    localparam int COUNT_W     = 16;
    localparam int DIST_W      = SUM_W / 2;
    localparam int SQRT_STEPS  = DIST_W;
    localparam int REM_W       = DIST_W + 2;
    localparam int STEP_W      = $clog2(SQRT_STEPS);
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a_element;
        logic signed [ELEM_W-1:0] b_element;
        logic                     last;
    } edu_in_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [SUM_W-1:0]   squared_distance;
        logic [COUNT_W-1:0] element_count;
        logic               overflow;
    } edu_out_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic               sat;
    } edu_vec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } edu_state_t;

endpackage

// ----- sv/euclidean_distance_unit.sv -----
`timescale 1ns / 1ps
// Euclidean distance unit, top level. Instantiates edu_front, edu_fifo and
// edu_back; uses edu_pkg.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one element pair per transaction,
//     signed Q8.8 a_element and b_element, last set on the final pair.
//   out channel (out_valid/out_ready/out_data): one transaction per vector with
//     floor sqrt distance (Q.8), saturated sum of squares (Q.16), pair count
//     and overflow flag.
//   Throughput: one pair per cycle while in_ready is high. The square root
//     takes one root bit per cycle in a single shared unit, so the back end
//     handles one vector at a time (pop, 24 root steps, then an output state
//     held until out_ready is high).
//   Finished sums wait in a DEPTH-entry queue; in_ready drops only when the
//     queue plus vector ends still in the two front pipeline stages fill it.
//   A stalled receiver holds the result stable; the front keeps streaming.
//   Reset clears the accumulator, the queue and the back-end state.
module euclidean_distance_unit
    import edu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  edu_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output edu_out_t out_data
);

    logic                       push;
    edu_vec_t                   push_data;
    logic                       pop;
    edu_vec_t                   pop_data;
    logic                       empty;
    logic [$clog2(DEPTH+1)-1:0] level;

    edu_front #(.DEPTH(DEPTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .queue_level (level),
        .push        (push),
        .push_data   (push_data)
    );

    edu_fifo #(.DEPTH(DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty),
        .level     (level)
    );

    edu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (empty),
        .queue_data  (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// ----- sv/edu_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts element pairs, forms |a-b|, squares it and accumulates
// with saturation; pushes one edu_vec_t per vector. Depends on edu_pkg.
module edu_front
    import edu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  edu_in_t                      in_data,
    input  logic [$clog2(DEPTH+1)-1:0]   queue_level,
    output logic                         push,
    output edu_vec_t                     push_data
);

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    logic               a_valid_reg;
    logic               a_last_reg;
    logic [MAG_W-1:0]   a_mag_reg;
    logic               b_valid_reg;
    logic               b_last_reg;
    logic [SQ_W-1:0]    b_sq_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               sat_reg;
    logic               sat_next;

    logic signed [ELEM_W:0] diff;
    logic [ELEM_W:0]        mag_wide;
    logic [SUM_W:0]         total;
    logic [1:0]             pending;
    logic                   accept;

    // Reserve a queue slot for every vector end still in the pipeline.
    assign pending  = {1'b0, a_valid_reg & a_last_reg} + {1'b0, b_valid_reg & b_last_reg};
    assign in_ready = (int'(queue_level) + int'(pending)) < DEPTH;
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        diff     = {in_data.a_element[ELEM_W-1], in_data.a_element}
                 - {in_data.b_element[ELEM_W-1], in_data.b_element};
        mag_wide = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_last_reg <= in_data.last;
        a_mag_reg  <= mag_wide[MAG_W-1:0];
        b_last_reg <= a_last_reg;
        b_sq_reg   <= a_mag_reg * a_mag_reg;
    end

    always_comb
    begin
        total      = {1'b0, sum_reg} + (SUM_W+1)'(b_sq_reg);
        sum_next   = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
        sat_next   = sat_reg | total[SUM_W];
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        push       = b_valid_reg & b_last_reg;
        push_data  = '{sum: sum_next, count: count_next, sat: sat_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (b_valid_reg)
        begin
            if (b_last_reg)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                sat_reg   <= 1'b0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                sat_reg   <= sat_next;
            end
        end
    end

endmodule

// ----- sv/edu_fifo.sv -----
`timescale 1ns / 1ps
// Small queue of finished vector sums between the front and back ends.
// Depends on edu_pkg.
module edu_fifo
    import edu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  edu_vec_t                   push_data,
    input  logic                       pop,
    output edu_vec_t                   pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH+1);

    edu_vec_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic             do_pop;

    assign empty    = (level_reg == '0);
    assign level    = level_reg;
    assign do_pop   = pop & ~empty;
    assign pop_data = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !do_pop)
                level_reg <= level_reg + 1'b1;
            else if (!push && do_pop)
                level_reg <= level_reg - 1'b1;
        end
    end

endmodule

// ----- sv/edu_back.sv -----
`timescale 1ns / 1ps
// Back end: bit-serial floor square root (one root bit per cycle) and the
// output register. Depends on edu_pkg.
module edu_back
    import edu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     queue_empty,
    input  edu_vec_t queue_data,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output edu_out_t out_data
);

    edu_state_t         state_reg;
    edu_state_t         state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   radicand_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DIST_W-1:0]  root_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               ovf_reg;

    logic [REM_W-1:0]   rem_shift;
    logic [REM_W-1:0]   trial;
    logic               fits;
    logic               last_step;

    assign rem_shift = {rem_reg[REM_W-3:0], radicand_reg[SUM_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = rem_shift >= trial;
    assign last_step = (int'(step_reg) == SQRT_STEPS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (last_step)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (state_reg == ST_CALC)
            step_reg <= last_step ? '0 : step_reg + 1'b1;
        else
            step_reg <= '0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            radicand_reg <= queue_data.sum;
            sum_reg      <= queue_data.sum;
            count_reg    <= queue_data.count;
            ovf_reg      <= queue_data.sat;
            rem_reg      <= '0;
            root_reg     <= '0;
        end
        else if (state_reg == ST_CALC)
        begin
            radicand_reg <= {radicand_reg[SUM_W-3:0], 2'b00};
            rem_reg      <= fits ? rem_shift - trial : rem_shift;
            root_reg     <= {root_reg[DIST_W-2:0], fits};
        end
    end

    assign out_data = '{distance:         root_reg,
                        squared_distance: sum_reg,
                        element_count:    count_reg,
                        overflow:         ovf_reg};

endmodule

// ----- sv/edu_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for euclidean_distance_unit and its bind.
// Depends on edu_pkg.
module edu_checker
    import edu_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input edu_out_t out_data
);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    logic [SUM_W-1:0] dist_sq;

    assign dist_sq = SUM_W'(out_data.distance) * SUM_W'(out_data.distance);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.element_count != '0)
        else $error("result with zero element count");

    a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |-> out_data.squared_distance == SUM_MAX)
        else $error("overflow flagged without saturated sum");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dist_sq <= out_data.squared_distance)
        else $error("distance squared exceeds sum of squares");

endmodule

bind euclidean_distance_unit edu_checker u_edu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- tb/euclidean_distance_unit_test.sv -----
`timescale 1ns / 1ps
// Testbench for euclidean_distance_unit: drives element pairs, predicts sum of squares,
// floor root, pair count and overflow per vector and checks every result in order.
// Depends on edu_pkg and the euclidean_distance_unit RTL.
module euclidean_distance_unit_test;

    import edu_pkg::*;

    localparam int                CYCLE_LIMIT  = 800000;
    localparam int                RANDOM_PAIRS = 930;
    localparam int                LONG_PAIRS   = 200;
    localparam int                DRAIN_CYCLES = 64;
    localparam int                HOLD_CYCLES  = 600;
    localparam longint unsigned   SUM_LIMIT    = (64'd1 << SUM_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

    class distance_scoreboard;
        logic [SUM_W-1:0]   square_total;
        logic [COUNT_W-1:0] pairs_seen;
        bit                 sum_clipped;
        edu_out_t           expected_q[$];
        int                 errors;

        function new();
            square_total = '0;
            pairs_seen   = '0;
            sum_clipped  = 1'b0;
            errors       = 0;
        endfunction

        function logic [DIST_W-1:0] root_floor(logic [SUM_W-1:0] n);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int i = DIST_W - 1; i >= 0; i--)
            begin
                trial = root | (64'd1 << i);
                if (trial * trial <= n)
                    root = trial;
            end
            return root[DIST_W-1:0];
        endfunction

        function void note_pair(edu_in_t item);
            longint          diff;
            longint unsigned mag;
            longint unsigned total;
            edu_out_t        res;
            diff  = longint'($signed(item.a_element)) - longint'($signed(item.b_element));
            mag   = (diff < 0) ? -diff : diff;
            total = longint'(square_total) + mag * mag;
            if (total > SUM_LIMIT)
            begin
                square_total = SUM_LIMIT[SUM_W-1:0];
                sum_clipped  = 1'b1;
            end
            else
                square_total = total[SUM_W-1:0];
            if (pairs_seen != COUNT_LIMIT)
                pairs_seen++;
            if (item.last)
            begin
                res.distance         = root_floor(square_total);
                res.squared_distance = square_total;
                res.element_count    = pairs_seen;
                res.overflow         = sum_clipped;
                expected_q.push_back(res);
                square_total = '0;
                pairs_seen   = '0;
                sum_clipped  = 1'b0;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_result(edu_out_t got);
            edu_out_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected transaction, squared_distance=%0d",
                                 got.squared_distance));
                return;
            end
            want = expected_q.pop_front();
            if (got.distance !== want.distance)
                report($sformatf("distance %0d, want %0d", got.distance, want.distance));
            if (got.squared_distance !== want.squared_distance)
                report($sformatf("squared_distance %0d, want %0d",
                                 got.squared_distance, want.squared_distance));
            if (got.element_count !== want.element_count)
                report($sformatf("element_count %0d, want %0d",
                                 got.element_count, want.element_count));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow %0b, want %0b", got.overflow, want.overflow));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    edu_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    edu_out_t out_data;

    distance_scoreboard sb;
    int                 results_seen = 0;
    bit                 steady       = 1'b0;

    euclidean_distance_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                sb.check_result(out_data);
            end
            if (in_valid && in_ready)
                sb.note_pair(in_data);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_pair(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b, bit last);
        edu_in_t item;
        item.a_element = a;
        item.b_element = b;
        item.last      = last;
        while (!steady && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic [ELEM_W-1:0] edge_value();
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // receiver: random stalls, one long hold-off to back the block up
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 20)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 24);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("euclidean_distance_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        int               sent;
        int               vec;
        int               len;
        int               mode;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-pair vectors at the extremes
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h7FFF, 16'h8000, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b1);
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'h7FFF, 16'h7FFF, 1'b1);
        send_pair(16'hFFFF, 16'h0001, 1'b1);
        // short vectors, results only on the pair marked last
        send_pair(16'h0001, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'h0001, 1'b1);
        send_pair(16'h0100, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'hFF00, 1'b0);
        send_pair(16'hFF00, 16'h0100, 1'b1);
        send_pair(16'h5555, 16'hAAAA, 1'b0);
        send_pair(16'hAAAA, 16'h5555, 1'b1);
        send_pair(16'h7FFF, 16'h8000, 1'b0);
        send_pair(16'h8000, 16'h7FFF, 1'b0);
        send_pair(16'h1234, 16'h1234, 1'b1);
        // long vector of largest differences
        for (int i = 0; i < LONG_PAIRS; i++)
            send_pair(16'h7FFF, 16'h8000, i == LONG_PAIRS - 1);
        send_pair(16'h0003, 16'h0000, 1'b1);

        sent = 0;
        vec  = 0;
        while (sent < RANDOM_PAIRS)
        begin
            steady = (vec >= 20 && vec < 60);
            len = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(40, 9);
            for (int i = 0; i < len; i++)
            begin
                mode = $urandom_range(99);
                a = ELEM_W'($urandom());
                b = ELEM_W'($urandom());
                if (mode < 30)
                begin
                    a = 16'($urandom_range(1024)) - 16'd512;
                    b = 16'($urandom_range(1024)) - 16'd512;
                end
                else if (mode < 45)
                begin
                    a = edge_value();
                    b = edge_value();
                end
                else if (mode < 60)
                    b = a + 16'($urandom_range(8)) - 16'd4;
                send_pair(a, b, i == len - 1);
            end
            sent += len;
            vec++;
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("euclidean_distance_unit_test OK");
        else
            $display("euclidean_distance_unit_test NOT OK");
        $finish;
    end

endmodule
